FILE: rtl/core/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and constants for the strobe-driven memory emulator.
// ----------------------------------------------------------------------------
package dsm_pkg;

	localparam int ADDR_BUS_W = 7;
	localparam int DATA_W     = 8;

	localparam int ROW_BITS_DEF  = 7;
	localparam int COL_BITS_DEF  = 7;
	localparam int MEM_DEPTH_DEF = 16384;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_ROW   = 2'd1,
		KIND_READ  = 2'd2,
		KIND_WRITE = 2'd3
	} dsm_kind_t;

	typedef struct packed {
		logic                  ras_n;
		logic                  cas_n;
		logic                  wr_n;
		logic [ADDR_BUS_W-1:0] addr_bus;
		logic [DATA_W-1:0]     data_in;
	} dsm_in_word_t;

	typedef struct packed {
		logic              drive_data;
		logic [DATA_W-1:0] data_out;
		dsm_kind_t         access_kind;
	} dsm_out_word_t;

endpackage

FILE: rtl/core/dsm_in_if.sv
// ----------------------------------------------------------------------------
// dsm_in_if
// Valid/ready channel carrying one pin sample word.
// ----------------------------------------------------------------------------
interface dsm_in_if;
	import dsm_pkg::*;

	logic         valid;
	logic         ready;
	dsm_in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/core/dsm_out_if.sv
// ----------------------------------------------------------------------------
// dsm_out_if
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface dsm_out_if;
	import dsm_pkg::*;

	logic          valid;
	logic          ready;
	dsm_out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/core/dsm_ram.sv
// ----------------------------------------------------------------------------
// dsm_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dsm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: rtl/core/dram_strobe_memory_emulator_unit.sv
// ----------------------------------------------------------------------------
// dram_strobe_memory_emulator_unit
// Multiplexed-address DRAM stand-in driven by sampled strobe pins.
// ----------------------------------------------------------------------------
// Each sample word carries the levels of RAS, CAS, the write line, the address
// bus and the data bus; every sample gives exactly one result word. A strobe
// falling edge starts an access: with CAS low it reads or writes the byte at
// row * 2^COL_BITS + column, otherwise it latches the row (page mode keeps the
// row). A read drives the stored byte until either strobe rises. The unit takes
// one sample word per clock unless a stalled result backs up the pipeline; the
// single port of the byte store carries one read or one write per word, and the
// strobe, row and drive state are decided as the word enters.
// A two-register pipeline (store read, then output register) lets a new word in
// while a finished result waits. The store holds no reset value: reading a byte
// that was never written returns whatever the RAM holds.
// ----------------------------------------------------------------------------
module dram_strobe_memory_emulator_unit #(
	parameter int ROW_BITS  = dsm_pkg::ROW_BITS_DEF,
	parameter int COL_BITS  = dsm_pkg::COL_BITS_DEF,
	parameter int MEM_DEPTH = dsm_pkg::MEM_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dsm_in_if.sink    sample,
	dsm_out_if.source result
);
	import dsm_pkg::*;

	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int EXT_W  = ADDR_BUS_W + ROW_BITS + COL_BITS + ADDR_W;

	// Strobe and drive state, updated as each word is accepted
	logic [1:0]          prev_q;     // bit0 RAS, bit1 CAS
	logic                drive_q;
	logic [ROW_BITS-1:0] row_q;
	logic [DATA_W-1:0]   held_q;

	// Pipeline: s1 waits for store read data, s2 is the output register
	logic          v_s1;
	dsm_kind_t     kind_s1;
	logic          drive_s1;
	logic          v_s2;
	dsm_out_word_t word_s2;

	logic adv_s1, adv_s2, acc;

	// Decode of the incoming word
	logic [1:0]          now, fell;
	logic [EXT_W-1:0]    abus_ext, full_addr;
	logic [COL_BITS-1:0] col;
	dsm_kind_t           kind_d;
	logic                drive_d, drive_next, row_we, ram_we, ram_re;
	logic [ADDR_W-1:0]   ram_addr;
	logic [DATA_W-1:0]   ram_rdata, data_sel;

	assign adv_s2       = !v_s2 || result.ready;
	assign adv_s1       = v_s1 && adv_s2;
	assign sample.ready = !v_s1 || adv_s2;
	assign acc          = sample.valid && sample.ready;

	assign now       = {sample.data.cas_n, sample.data.ras_n};
	assign fell      = prev_q & ~now;
	assign abus_ext  = EXT_W'(sample.data.addr_bus);
	assign col       = abus_ext[COL_BITS-1:0];
	assign full_addr = EXT_W'({row_q, col});
	assign ram_addr  = full_addr[ADDR_W-1:0];

	// Classify the sample: held drive, edge-started access, or nothing
	always_comb begin
		kind_d     = KIND_NONE;
		drive_d    = 1'b0;
		drive_next = 1'b0;
		row_we     = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		if (drive_q) begin
			// ignore edges; keep driving while both strobes stay low
			drive_d    = (now == 2'b00);
			drive_next = (now == 2'b00);
		end else if (fell != 2'b00) begin
			if (!sample.data.cas_n) begin
				if (sample.data.wr_n) begin
					kind_d     = KIND_READ;
					drive_d    = 1'b1;
					drive_next = 1'b1;
					ram_re     = acc;
				end else begin
					kind_d = KIND_WRITE;
					ram_we = acc;
				end
			end else begin
				kind_d = KIND_ROW;
				row_we = 1'b1;
			end
		end
	end

	dsm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MEM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (sample.data.data_in),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 2'b11;
			drive_q <= 1'b0;
			row_q   <= '0;
		end else if (acc) begin
			prev_q  <= now;
			drive_q <= drive_next;
			if (row_we) begin
				row_q <= abus_ext[ROW_BITS-1:0];
			end
		end
	end

	// Stage 1: hold the decoded kind while the store read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1  <= kind_d;
			drive_s1 <= drive_d;
		end
	end

	// A read start takes fresh store data; a held drive repeats the held byte
	assign data_sel = (kind_s1 == KIND_READ) ? ram_rdata : held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (adv_s1 && kind_s1 == KIND_READ) begin
			held_q <= ram_rdata;
		end
	end

	// Stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_s2.drive_data  <= drive_s1;
			word_s2.data_out    <= drive_s1 ? data_sel : '0;
			word_s2.access_kind <= kind_s1;
		end
	end

	assign result.valid = v_s2;
	assign result.data  = word_s2;

endmodule

FILE: rtl/core/dsm_chk.sv
// ----------------------------------------------------------------------------
// dsm_chk
// Port-level checks on the emulator result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dsm_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           drive_data,
	input logic [dsm_pkg::DATA_W-1:0]     data_out,
	input dsm_pkg::dsm_kind_t             access_kind
);
	import dsm_pkg::*;

	logic out_acc;
	assign out_acc = out_valid && out_ready;

	// an idle bus shows zero data
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drive_data |-> data_out == '0)
		else $error("data_out not zero while bus not driven");

	// a read start always drives
	a_read_drives: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && access_kind == KIND_READ |-> drive_data)
		else $error("read start without drive");

	// a continued drive repeats the byte of the word before it
	a_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && drive_data && access_kind == KIND_NONE
		&& $past(out_acc) && $past(drive_data) |-> data_out == $past(data_out))
		else $error("held read byte changed during drive");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out)
		&& $stable(drive_data) && $stable(access_kind))
		else $error("result word changed while stalled");

endmodule

bind dram_strobe_memory_emulator_unit dsm_chk u_dsm_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.drive_data  (result.data.drive_data),
	.data_out    (result.data.data_out),
	.access_kind (result.data.access_kind)
);

FILE: bench/tb_dram_strobe_memory_emulator_unit.sv
// ----------------------------------------------------------------------------
// tb_dram_strobe_memory_emulator_unit
// Self-checking bench for the strobe-driven memory emulator.
// ----------------------------------------------------------------------------
// Pin sample words are driven on the input channel and every result word is
// checked against a cycle-free prediction of the emulator: strobe edge
// detection, row latch, page-mode column accesses, read drive and release. A
// short directed sequence comes first, then random RAS/CAS bursts with noise
// under three idling regimes. Reads are only issued to bytes that have been
// written, so the undefined contents of the store are never observed.
// ----------------------------------------------------------------------------
module tb_dram_strobe_memory_emulator_unit;
	import dsm_pkg::*;

	localparam int ADDR_W      = ROW_BITS_DEF + COL_BITS_DEF;
	localparam int MEM_WORDS   = MEM_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int MAX_REPORTS = 10;
	localparam int PHASE_WORDS = 430;

	// Strobe and drive state of the emulator, without the byte store
	typedef struct {
		logic [1:0]            last_strobes; // bit 0 RAS, bit 1 CAS
		logic [ROW_BITS_DEF-1:0] row;
		logic                  driving;
		logic [DATA_W-1:0]     held_byte;
	} strobe_track_t;

	logic clk;
	logic arst_n;

	dsm_in_if  pin_bus ();
	dsm_out_if result_bus ();

	dram_strobe_memory_emulator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (pin_bus),
		.result (result_bus)
	);

	// Live prediction state, advanced as each pin word is accepted
	strobe_track_t     live_track;
	logic [DATA_W-1:0] model_store [MEM_WORDS];

	// Planning state, advanced as each pin word is queued
	strobe_track_t plan_track;
	bit            byte_written [MEM_WORDS];

	dsm_in_word_t  pins_pending [$];
	dsm_out_word_t expected_results [$];

	int  queued_words;
	int  mismatches;
	int  cycle_count;
	int  sender_idle_pct;
	int  receiver_idle_pct;
	int  hold_left;
	bit  long_hold_request;
	bit  pin_word_taken;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Advance the strobe state by one pin sample; return the access it starts
	function automatic dsm_kind_t advance_strobes(inout strobe_track_t st,
			input dsm_in_word_t w, output logic [ADDR_W-1:0] addr);
		logic [1:0] now;
		dsm_kind_t  kind;
		now  = {w.cas_n, w.ras_n};
		kind = KIND_NONE;
		addr = {st.row, w.addr_bus[COL_BITS_DEF-1:0]};
		if (st.driving) begin
			// edges are ignored while driving; either strobe high releases
			if (now != 2'b00)
				st.driving = 1'b0;
		end else if ((st.last_strobes & ~now) != 2'b00) begin
			if (!w.cas_n) begin
				// CAS low on any falling edge: column access
				kind = w.wr_n ? KIND_READ : KIND_WRITE;
				if (w.wr_n)
					st.driving = 1'b1;
			end else begin
				st.row = w.addr_bus[ROW_BITS_DEF-1:0];
				kind   = KIND_ROW;
			end
		end
		st.last_strobes = now;
		return kind;
	endfunction

	// Work out the result word that one accepted pin word gives
	function automatic dsm_out_word_t predict_result(input dsm_in_word_t w);
		dsm_out_word_t     res;
		logic [ADDR_W-1:0] addr;
		logic              was_driving;
		dsm_kind_t         kind;
		was_driving = live_track.driving;
		kind        = advance_strobes(live_track, w, addr);
		res         = '0;
		if (kind == KIND_READ) begin
			live_track.held_byte = model_store[addr];
			res.drive_data       = 1'b1;
			res.data_out         = live_track.held_byte;
		end else if (kind == KIND_WRITE) begin
			model_store[addr] = w.data_in;
		end else if (was_driving && live_track.driving) begin
			res.drive_data = 1'b1;
			res.data_out   = live_track.held_byte;
		end
		res.access_kind = kind;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------------

	// Queue one pin word; turn a read of a never-written byte into a write
	task automatic queue_pins(input logic ras, input logic cas, input logic wr,
			input logic [ADDR_BUS_W-1:0] a, input logic [DATA_W-1:0] d);
		dsm_in_word_t      w;
		strobe_track_t     probe;
		logic [ADDR_W-1:0] addr;
		dsm_kind_t         kind;
		w.ras_n    = ras;
		w.cas_n    = cas;
		w.wr_n     = wr;
		w.addr_bus = a;
		w.data_in  = d;
		probe      = plan_track;
		kind       = advance_strobes(probe, w, addr);
		if (kind == KIND_READ && !byte_written[addr]) begin
			w.wr_n = 1'b0;
			probe  = plan_track;
			kind   = advance_strobes(probe, w, addr);
		end
		if (kind == KIND_WRITE)
			byte_written[addr] = 1'b1;
		plan_track = probe;
		pins_pending.push_back(w);
		queued_words++;
	endtask

	// Random field values at the widths of the pin word
	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	function automatic logic [ADDR_BUS_W-1:0] rand_addr();
		return ADDR_BUS_W'($urandom_range(127));
	endfunction

	function automatic logic [DATA_W-1:0] rand_byte();
		return DATA_W'($urandom_range(255));
	endfunction

	// Mostly a handful of rows and columns, so that reads find written bytes
	function automatic logic [ADDR_BUS_W-1:0] pick_row();
		return ADDR_BUS_W'(($urandom_range(99) < 70) ? $urandom_range(3)
			: $urandom_range(127));
	endfunction

	function automatic logic [ADDR_BUS_W-1:0] pick_column();
		return ADDR_BUS_W'(($urandom_range(99) < 70) ? $urandom_range(7)
			: $urandom_range(127));
	endfunction

	task automatic queue_noise();
		repeat ($urandom_range(1, 4))
			queue_pins(rand_bit(), rand_bit(), rand_bit(), rand_addr(), rand_byte());
	endtask

	// One well-formed RAS access with one to three page-mode CAS accesses
	task automatic queue_page_burst();
		if ($urandom_range(3) == 0)
			queue_pins(1'b1, 1'b1, rand_bit(), rand_addr(), rand_byte());
		if ($urandom_range(4) == 0) begin
			// CAS first, then RAS falls with CAS already low
			queue_pins(1'b1, 1'b0, rand_bit(), pick_column(), rand_byte());
			queue_pins(1'b0, 1'b0, rand_bit(), pick_column(), rand_byte());
			queue_pins(1'b0, 1'b1, rand_bit(), rand_addr(), rand_byte());
		end else begin
			queue_pins(1'b0, 1'b1, rand_bit(), pick_row(), rand_byte());
		end
		repeat ($urandom_range(1, 3)) begin
			queue_pins(1'b0, 1'b0, rand_bit(), pick_column(), rand_byte());
			repeat ($urandom_range(2))
				queue_pins(1'b0, 1'b0, rand_bit(), rand_addr(), rand_byte());
			queue_pins(1'b0, 1'b1, rand_bit(), rand_addr(), rand_byte());
		end
		queue_pins(1'b1, 1'b1, rand_bit(), rand_addr(), rand_byte());
	endtask

	task automatic queue_random_phase(input int words);
		int target;
		target = queued_words + words;
		while (queued_words < target) begin
			if ($urandom_range(99) < 85)
				queue_page_burst();
			else
				queue_noise();
		end
	endtask

	// Hold until every queued word is taken and every result has come back
	task automatic wait_drained();
		while (pins_pending.size() != 0 || pin_bus.valid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// ------------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n            = 1'b0;
		pin_bus.valid     = 1'b0;
		pin_bus.data      = '0;
		result_bus.ready  = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// ------------------------------------------------------------------------
	// Driver: offer pending pin words at the falling edge
	// ------------------------------------------------------------------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (!pin_bus.valid || pin_word_taken) begin
				pin_word_taken = 1'b0;
				if (pins_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					pin_bus.data  <= pins_pending.pop_front();
					pin_bus.valid <= 1'b1;
				end else begin
					pin_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (long_hold_request) begin
				hold_left         = LONG_HOLD;
				long_hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on accepted pin words, check accepted result words
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		dsm_out_word_t want;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("FAIL dram_strobe_memory_emulator_unit");
				$finish;
			end
			if (pin_bus.valid && pin_bus.ready) begin
				expected_results.push_back(predict_result(pin_bus.data));
				pin_word_taken = 1'b1;
			end
			if (result_bus.valid && result_bus.ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch("result word with none expected");
				end else begin
					want = expected_results.pop_front();
					if (result_bus.data.drive_data !== want.drive_data)
						note_mismatch($sformatf("drive_data expected %0d got %0d",
							want.drive_data, result_bus.data.drive_data));
					if (result_bus.data.data_out !== want.data_out)
						note_mismatch($sformatf("data_out expected %02h got %02h",
							want.data_out, result_bus.data.data_out));
					if (result_bus.data.access_kind !== want.access_kind)
						note_mismatch($sformatf("access_kind expected %0d got %0d",
							want.access_kind, result_bus.data.access_kind));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------------

	initial begin
		live_track        = '{2'b11, '0, 1'b0, '0};
		plan_track        = '{2'b11, '0, 1'b0, '0};
		queued_words      = 0;
		mismatches        = 0;
		cycle_count       = 0;
		hold_left         = 0;
		long_hold_request = 1'b0;
		pin_word_taken    = 1'b0;
		sender_idle_pct   = 29;
		receiver_idle_pct = 58;
		for (int i = 0; i < MEM_WORDS; i++) begin
			byte_written[i] = 1'b0;
			model_store[i]  = '0;
		end

		// Directed: extremes of row, column and data, page mode, read drive
		queue_pins(1'b1, 1'b1, 1'b1, 7'd0,   8'h00); // idle
		queue_pins(1'b0, 1'b1, 1'b1, 7'd127, 8'h00); // row 127
		queue_pins(1'b0, 1'b0, 1'b0, 7'd127, 8'hff); // write top byte
		queue_pins(1'b0, 1'b1, 1'b1, 7'd0,   8'h00); // CAS up, row kept
		queue_pins(1'b0, 1'b0, 1'b0, 7'd0,   8'h00); // page-mode write, column 0
		queue_pins(1'b0, 1'b1, 1'b1, 7'd0,   8'h00);
		queue_pins(1'b0, 1'b0, 1'b1, 7'd127, 8'h00); // read back top byte
		queue_pins(1'b0, 1'b0, 1'b0, 7'd1,   8'h55); // write line ignored while driving
		queue_pins(1'b0, 1'b1, 1'b1, 7'd0,   8'h00); // CAS up releases the drive
		queue_pins(1'b1, 1'b1, 1'b1, 7'd0,   8'h00);
		queue_pins(1'b0, 1'b1, 1'b1, 7'd0,   8'h00); // row 0
		queue_pins(1'b0, 1'b0, 1'b0, 7'd0,   8'ha5); // write row 0 column 0
		queue_pins(1'b1, 1'b1, 1'b1, 7'd0,   8'h00);
		queue_pins(1'b1, 1'b0, 1'b1, 7'd0,   8'h00); // CAS alone: read with RAS high
		queue_pins(1'b1, 1'b0, 1'b1, 7'd0,   8'h00); // released at once, RAS high
		queue_pins(1'b1, 1'b1, 1'b1, 7'd0,   8'h00);
		queue_pins(1'b1, 1'b0, 1'b0, 7'd5,   8'h3c); // CAS-only write, column 5
		queue_pins(1'b0, 1'b0, 1'b1, 7'd0,   8'h00); // RAS falls with CAS low: read
		queue_pins(1'b0, 1'b0, 1'b1, 7'd0,   8'h00); // keep driving
		queue_pins(1'b1, 1'b0, 1'b1, 7'd0,   8'h00); // RAS up releases the drive
		queue_pins(1'b1, 1'b1, 1'b1, 7'd0,   8'h00);
		queue_pins(1'b0, 1'b1, 1'b1, 7'd0,   8'h00);
		queue_pins(1'b0, 1'b0, 1'b1, 7'd5,   8'h00); // read column 5 of row 0
		queue_pins(1'b1, 1'b1, 1'b1, 7'd0,   8'h00);
		wait_drained();

		// Random, sender idling lightly and receiver heavily
		queue_random_phase(PHASE_WORDS);
		wait_drained();

		// Random, the other way round
		sender_idle_pct   = 58;
		receiver_idle_pct = 29;
		queue_random_phase(PHASE_WORDS);
		wait_drained();

		// Random at full rate, with one long receiver hold to back the block up
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		queue_random_phase(PHASE_WORDS);
		long_hold_request = 1'b1;
		wait_drained();

		// Let any stray result word surface before deciding
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS dram_strobe_memory_emulator_unit");
		else
			$display("FAIL dram_strobe_memory_emulator_unit");
		$finish;
	end

endmodule
